FILE: hdl/pfde_pkg.sv
// shared types and constants for the page framebuffer draw engine
// no dependencies; imported by pfde_front, pfde_queue, pfde_back and the top level
package pfde_pkg;

    localparam int DEF_SCREEN_COLS = 128;
    localparam int DEF_SCREEN_ROWS = 32;

    // widest fields over the supported screen sizes (256 columns, 64 rows)
    localparam int PAGE_MAX_W = 3;
    localparam int ADDR_MAX_W = 11;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] LOW_SEVEN = 8'h7F;

    localparam logic [2:0] MODE_PIXEL   = 3'd0;
    localparam logic [2:0] MODE_RECT    = 3'd1;
    localparam logic [2:0] MODE_VLINE   = 3'd2;
    localparam logic [2:0] MODE_COLMASK = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;
    localparam logic [2:0] MODE_READ    = 3'd5;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_DRAW  = 3'd1,
        OP_MASK  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [7:0]            x;
        logic [7:0]            y;
        logic [7:0]            w;
        logic [7:0]            h;
        logic                  ink;
        logic [PAGE_MAX_W-1:0] page_first;
        logic [PAGE_MAX_W-1:0] page_last;
        logic [ADDR_MAX_W-1:0] base;
        logic                  rejected;
        logic [8:0]            cursor_col;
        logic [7:0]            cursor_row;
    } cmd_t;

endpackage

FILE: hdl/pfde_front.sv
// command front end: input handshake, range checks, command classification, text cursor
// depends on pfde_pkg
module pfde_front import pfde_pkg::*; #(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [7:0] s_pos_x,
    input  logic [7:0] s_pos_y,
    input  logic [7:0] s_extent_w,
    input  logic [7:0] s_extent_h,
    input  logic       s_ink,
    input  logic [8:0] s_read_addr,
    input  logic       init_done,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_entry
);

    localparam int PAGE_COUNT  = (SCREEN_ROWS + 7) / 8;
    localparam int STORE_BYTES = SCREEN_COLS * PAGE_COUNT;
    localparam logic [8:0]  COLS_L   = 9'(SCREEN_COLS);
    localparam logic [8:0]  ROWS_L   = 9'(SCREEN_ROWS);
    localparam logic [11:0] COLS_12  = 12'(SCREEN_COLS);
    localparam logic [11:0] STORE_12 = 12'(STORE_BYTES);
    localparam logic [PAGE_MAX_W-1:0] PAGE_LAST = PAGE_MAX_W'(PAGE_COUNT - 1);

    logic [8:0]  text_col_reg, text_col_next;
    logic [7:0]  text_row_reg, text_row_next;
    logic        accept;
    logic        x_in, y_in;
    logic [8:0]  line_end, line_last;
    logic [11:0] mask_base;

    assign s_ready = init_done && !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    assign x_in      = {1'b0, s_pos_x} < COLS_L;
    assign y_in      = {1'b0, s_pos_y} < ROWS_L;
    assign line_end  = {1'b0, s_pos_y} + {1'b0, s_extent_h};
    assign line_last = line_end - 9'd1;
    assign mask_base = {4'd0, s_pos_x} + ({7'd0, s_pos_y[7:3]} * COLS_12);

    always_comb begin
        text_col_next      = text_col_reg;
        text_row_next      = text_row_reg;
        q_entry.op         = OP_NOP;
        q_entry.x          = s_pos_x;
        q_entry.y          = s_pos_y;
        q_entry.w          = s_extent_w;
        q_entry.h          = s_extent_h;
        q_entry.ink        = s_ink;
        q_entry.page_first = '0;
        q_entry.page_last  = '0;
        q_entry.base       = '0;
        q_entry.rejected   = 1'b0;
        case (s_mode)
            MODE_PIXEL: begin
                if (x_in && y_in) begin
                    q_entry.op         = OP_DRAW;
                    q_entry.w          = 8'd1;
                    q_entry.h          = 8'd1;
                    q_entry.page_first = s_pos_y[5:3];
                    q_entry.page_last  = s_pos_y[5:3];
                end else begin
                    q_entry.rejected = 1'b1;
                end
            end
            MODE_RECT: begin
                if (s_extent_w != 8'd0 && s_extent_h != 8'd0) begin
                    q_entry.op        = OP_DRAW;
                    q_entry.page_last = PAGE_LAST;
                end
            end
            MODE_VLINE: begin
                if (s_extent_h != 8'd0 && (line_end >= ROWS_L || !x_in)) begin
                    q_entry.rejected = 1'b1;
                end else begin
                    text_col_next = {1'b0, s_pos_x} + 9'd1;
                    text_row_next = s_pos_y;
                    if (s_extent_h != 8'd0) begin
                        q_entry.op         = OP_DRAW;
                        q_entry.w          = 8'd1;
                        q_entry.page_first = s_pos_y[5:3];
                        q_entry.page_last  = line_last[5:3];
                    end
                end
            end
            MODE_COLMASK: begin
                if (x_in && y_in) begin
                    q_entry.op   = OP_MASK;
                    q_entry.w    = 8'd1;
                    q_entry.base = mask_base[ADDR_MAX_W-1:0];
                end else begin
                    q_entry.rejected = 1'b1;
                end
            end
            MODE_CLEAR: begin
                q_entry.op = OP_CLEAR;
            end
            MODE_READ: begin
                if ({3'd0, s_read_addr} < STORE_12) begin
                    q_entry.op   = OP_READ;
                    q_entry.w    = 8'd1;
                    q_entry.base = {2'd0, s_read_addr};
                end
            end
            default: begin
            end
        endcase
        q_entry.cursor_col = text_col_next;
        q_entry.cursor_row = text_row_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_col_reg <= '0;
            text_row_reg <= '0;
        end else if (accept) begin
            text_col_reg <= text_col_next;
            text_row_reg <= text_row_next;
        end
    end

endmodule

FILE: hdl/pfde_queue.sv
// short command queue between the front end and the drawing back end
// depends on pfde_pkg
module pfde_queue import pfde_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_entry,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full  = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entries[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/pfde_back.sv
// drawing back end: framebuffer memory, read-modify-write walker, clear sweep, result register
// depends on pfde_pkg
module pfde_back import pfde_pkg::*; #(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       init_done,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_rejected,
    output logic [8:0] m_cursor_col,
    output logic [7:0] m_cursor_row
);

    localparam int PAGE_COUNT  = (SCREEN_ROWS + 7) / 8;
    localparam int STORE_BYTES = SCREEN_COLS * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [8:0]  COLS_L  = 9'(SCREEN_COLS);
    localparam logic [6:0]  ROWS_L  = 7'(SCREEN_ROWS);
    localparam logic [11:0] COLS_12 = 12'(SCREEN_COLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DONE  = 5'b01000,
        S_CLEAR = 5'b10000
    } state_t;

    logic [7:0] mem [STORE_BYTES];

    state_t                state_reg, state_next;
    logic                  init_reg, init_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [7:0]            col_i_reg, col_i_next;
    logic [PAGE_MAX_W-1:0] page_reg, page_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                  wr_pend_reg;
    logic [ADDR_W-1:0]     wr_addr_reg;
    logic [7:0]            wr_mask_reg;
    logic                  wr_ink_reg;
    logic [7:0]            mem_q_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_read_data_reg;
    logic                  m_rejected_reg;
    logic [8:0]            m_cursor_col_reg;
    logic [7:0]            m_cursor_row_reg;

    cmd_t                  cur;
    logic [7:0]            cur_i;
    logic [PAGE_MAX_W-1:0] cur_p;
    logic [7:0]            col;
    logic                  col_ok;
    logic [11:0]           draw_addr;
    logic [ADDR_W-1:0]     issue_addr;
    logic [7:0]            row_mask, issue_mask;
    logic                  issue_write, issue, step_last, out_free, finish;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [7:0]            mem_wdata;

    assign init_done = !init_reg;

    // current step comes straight from the queue head in the cycle a command starts
    assign cur   = (state_reg == S_IDLE) ? q_head : cmd_reg;
    assign cur_i = (state_reg == S_IDLE) ? 8'd0 : col_i_reg;
    assign cur_p = (state_reg == S_IDLE) ? q_head.page_first : page_reg;

    assign col       = cur.x + cur_i;
    assign col_ok    = {1'b0, col} < COLS_L;
    assign draw_addr = {4'd0, col} + ({9'd0, cur_p} * COLS_12);
    assign issue_addr = (cur.op == OP_DRAW) ? draw_addr[ADDR_W-1:0] : cur.base[ADDR_W-1:0];

    always_comb begin
        logic [5:0] row;
        logic [7:0] diff;
        for (int b = 0; b < 8; b++) begin
            row         = {cur_p, 3'(b)};
            diff        = {2'd0, row} - cur.y;
            row_mask[b] = ({1'b0, row} < ROWS_L) && (diff < cur.h);
        end
    end

    assign issue_mask  = (cur.op == OP_MASK) ? LOW_SEVEN : row_mask;
    assign issue_write = (cur.op == OP_MASK) || (cur.op == OP_DRAW && col_ok);
    assign step_last   = (cur_i == cur.w - 8'd1) && (cur_p == cur.page_last);

    assign q_pop = (state_reg == S_IDLE) && !q_empty;
    assign issue = (q_pop && (q_head.op == OP_DRAW || q_head.op == OP_MASK
                              || q_head.op == OP_READ))
                   || (state_reg == S_RUN);

    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == S_DRAIN || state_reg == S_DONE) && out_free;

    always_comb begin
        state_next    = state_reg;
        init_next     = init_reg;
        cmd_next      = cmd_reg;
        clr_addr_next = clr_addr_reg;
        col_i_next    = col_i_reg;
        page_next     = page_reg;
        if (cur_p == cur.page_last) begin
            col_i_next = cur_i + 8'd1;
            page_next  = cur.page_first;
        end else begin
            col_i_next = cur_i;
            page_next  = cur_p + 1'b1;
        end
        case (state_reg)
            S_IDLE: begin
                if (q_pop) begin
                    cmd_next = q_head;
                    case (q_head.op)
                        OP_DRAW, OP_MASK, OP_READ: begin
                            state_next = step_last ? S_DRAIN : S_RUN;
                        end
                        OP_CLEAR: begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (step_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = out_free ? S_IDLE : S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_DONE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // one write port shared by the modify step and the clear sweep
    always_comb begin
        mem_we    = wr_pend_reg || (state_reg == S_CLEAR);
        mem_waddr = wr_pend_reg ? wr_addr_reg : clr_addr_reg;
        mem_wdata = 8'd0;
        if (wr_pend_reg) begin
            mem_wdata = wr_ink_reg ? (mem_q_reg | wr_mask_reg) : (mem_q_reg & ~wr_mask_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            mem_q_reg <= mem[issue_addr];
        end
    end

    assign m_valid_next = finish || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            init_reg     <= 1'b1;
            clr_addr_reg <= '0;
            wr_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_reg     <= init_next;
            clr_addr_reg <= clr_addr_next;
            wr_pend_reg  <= issue && issue_write;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        col_i_reg   <= col_i_next;
        page_reg    <= page_next;
        wr_addr_reg <= issue_addr;
        wr_mask_reg <= issue_mask;
        wr_ink_reg  <= cur.ink;
        if (finish) begin
            m_read_data_reg  <= (cmd_reg.op == OP_READ) ? mem_q_reg : 8'd0;
            m_rejected_reg   <= cmd_reg.rejected;
            m_cursor_col_reg <= cmd_reg.cursor_col;
            m_cursor_row_reg <= cmd_reg.cursor_row;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_read_data_reg;
    assign m_rejected   = m_rejected_reg;
    assign m_cursor_col = m_cursor_col_reg;
    assign m_cursor_row = m_cursor_row_reg;

`ifndef NO_ASSERTIONS
    // a new command never starts while a byte write is still outstanding
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !wr_pend_reg)
        else $error("write pending while idle");

    // a pending write always follows a read issued in the previous cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pend_reg |-> $past(issue))
        else $error("write without prior read");

    // the power-up sweep runs alone and produces no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |-> (state_reg == S_CLEAR) && !m_valid_reg && !q_pop)
        else $error("activity during power-up clear");

    // the drain step only follows the last read of a walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN) |-> $past(issue && step_last))
        else $error("drain without final read");
`endif

endmodule

FILE: hdl/page_framebuffer_draw_engine.sv
// top level of the page framebuffer draw engine
// depends on pfde_pkg, pfde_front, pfde_queue, pfde_back
//
// Monochrome framebuffer of SCREEN_COLS x ceil(SCREEN_ROWS/8) bytes in page layout, one result
// per command. Every command passes a front end that checks ranges and tracks the text cursor,
// then a two-entry queue, then a back end that walks the framebuffer memory with one byte
// read-modify-write per cycle. A rectangle or vertical line is walked column by column, each
// page it touches in a column in turn; a clear sweeps the whole store to zero. After reset the
// block sweeps the store to zero with s_ready low. The memory has a single write port, shared
// by the modify step and the clear sweep. New commands are taken into the queue while it is not
// full, also while the back end works or a result waits on m_ready.
module page_framebuffer_draw_engine import pfde_pkg::*; #(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [7:0] s_pos_x,
    input  logic [7:0] s_pos_y,
    input  logic [7:0] s_extent_w,
    input  logic [7:0] s_extent_h,
    input  logic       s_ink,
    input  logic [8:0] s_read_addr,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_rejected,
    output logic [8:0] m_cursor_col,
    output logic [7:0] m_cursor_row
);

    cmd_t q_entry, q_head;
    logic q_push, q_full, q_pop, q_empty, init_done;

    pfde_front #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_extent_w  (s_extent_w),
        .s_extent_h  (s_extent_h),
        .s_ink       (s_ink),
        .s_read_addr (s_read_addr),
        .init_done   (init_done),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    pfde_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    pfde_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .init_done    (init_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_rejected   (m_rejected),
        .m_cursor_col (m_cursor_col),
        .m_cursor_row (m_cursor_row)
    );

endmodule
